### hdl/assert_macros.svh
// Assertion macros shared by the altitude block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ECA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent a fixed number of cycles later.
`define ECA_ASSERT_DELAY(label, clk, rst, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

### hdl/eca_pkg.sv
// Shared types, constants and tables for the ellipsoid altitude pipeline.
package eca_pkg;

  // CORDIC depth and the derived stage index width.
  localparam int CORDIC_STAGES = 32;
  localparam int CS_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  // Square root cells work on a 64-bit radicand, two bits per cell.
  localparam int SQRT_CELLS = 32;
  localparam int SQ_W = 5;

  // Restoring divider: one quotient bit per cell, quotient as wide as the radius.
  localparam int RE_W = 30;
  localparam int DIV_CELLS = RE_W;
  localparam int DV_W = 5;

  // Angles are Q2.30 radians held with headroom for differences.
  localparam int ANG_W = 34;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [63:0] INV_GAIN_Q30 = 64'sd652032874;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_RATIO  = 2'd1,
    REG_WINDOW = 2'd2
  } cfg_reg_t;

  // CORDIC cell operating mode and position in the chain.
  typedef enum logic {
    CM_VECTOR = 1'b0,
    CM_ROTATE = 1'b1
  } cordic_mode_t;

  typedef struct packed {
    cordic_mode_t    mode;
    logic [CS_W-1:0] stage;
  } cordic_ctl_t;

  // Side data that travels with each request down the pipeline.
  typedef struct packed {
    logic signed [31:0]      z;
    logic [32:0]             r;
    logic                    rxy_zero;
    logic signed [ANG_W-1:0] lat;
    logic                    pole;
    logic [31:0]             acl;
    logic                    dd_zero;
    logic                    over;
    logic [RE_W-1:0]         d;
    logic [RE_W-1:0]         ex;
    logic                    mu_zero;
  } tag_t;

  // Arctangent of 2^-i in Q2.30 radians; zero beyond the table.
  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      24: v = 34'sd63;
      25: v = 34'sd31;
      26: v = 34'sd15;
      27: v = 34'sd8;
      28: v = 34'sd4;
      29: v = 34'sd2;
      30: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hdl/ecef_to_ellipsoid_altitude.sv
// Top level: altitude above the reference ellipsoid from an earth-centred point.
// A request is taken in every cycle; busy never rises.
// done rises after the accepting edge once the request has passed the whole pipeline,
// which holds four CORDIC chains, three square root chains and the divider chain in series.
// The receiver cannot stall; each result is shown for exactly one cycle.
// rst clears the pipeline valid line and loads the register reset values.
module ecef_to_ellipsoid_altitude import eca_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] x_cm,
  input  logic signed [31:0] y_cm,
  input  logic signed [31:0] z_cm,
  output logic               done,
  output logic signed [31:0] altitude_cm,
  output logic               near_pole,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

`include "assert_macros.svh"

  localparam int N          = CORDIC_STAGES;
  localparam int ST_SQA     = 2;
  localparam int SQA_OUT    = ST_SQA + SQRT_CELLS;
  localparam int ST_Q       = SQA_OUT + 1;
  localparam int B_OUT      = ST_Q + N;
  localparam int ST_LAT     = B_OUT + 1;
  localparam int C_OUT      = ST_LAT + N;
  localparam int ST_T1      = C_OUT + 1;
  localparam int ST_T2      = ST_T1 + 1;
  localparam int ST_T3      = ST_T2 + 1;
  localparam int ST_T4      = ST_T3 + 1;
  localparam int D_OUT      = ST_T4 + SQRT_CELLS;
  localparam int ST_U1      = D_OUT + 1;
  localparam int ST_U2      = ST_U1 + 1;
  localparam int E_OUT      = ST_U2 + DIV_CELLS;
  localparam int ST_V1      = E_OUT + 1;
  localparam int ST_V2      = ST_V1 + 1;
  localparam int ST_V3      = ST_V2 + 1;
  localparam int ST_V4      = ST_V3 + 1;
  localparam int ST_V5      = ST_V4 + 1;
  localparam int F_OUT      = ST_V5 + SQRT_CELLS;
  localparam int ST_W1      = F_OUT + 1;
  localparam int G_OUT      = ST_W1 + N;
  localparam int ST_X1      = G_OUT + 1;
  localparam int H_OUT      = ST_X1 + N;
  localparam int ST_Y1      = H_OUT + 1;
  localparam int ST_Y2      = ST_Y1 + 1;
  localparam int LAT_LEN    = ST_Y2 + 1;
  localparam int DONE_DELAY = LAT_LEN;

  // Configuration registers and values derived from them.
  logic [RE_W-1:0] re;
  logic [30:0]     e;
  logic [19:0]     w;
  logic [60:0]     ree;
  logic [59:0]     re_sq;
  logic [RE_W-1:0] polar;

  // Valid line and side data line.
  logic [LAT_LEN-1:0] vld;
  tag_t               tag_line [LAT_LEN];
  tag_t               tag_next [LAT_LEN];
  tag_t               tag_in;

  // Plain pipeline registers between the chains.
  logic [31:0]             ax, ay, az;
  logic [63:0]             sq_x, sq_y, sq_z;
  logic [63:0]             pxy, prr;
  logic signed [63:0]      lat_x0, lat_y0;
  logic [31:0]             asl;
  logic [62:0]             ec_prod;
  logic [63:0]             asl_sq, asl_sq_d, ec_sq, dsum;
  logic [32:0]             den, den_d;
  logic [63:0]             clamp_prod;
  logic [61:0]             xa_prod;
  logic [RE_W-1:0]         xa;
  logic [59:0]             xa_sq;
  logic [60:0]             ex_prod;
  logic [59:0]             srad;
  logic signed [63:0]      mu_x0, mu_y0;
  logic signed [ANG_W-1:0] ang;
  logic signed [66:0]      prod;

  // Chain links: index 0 is the chain input.
  logic [63:0]             rxy_rem  [SQRT_CELLS+1];
  logic [63:0]             rxy_root [SQRT_CELLS+1];
  logic [63:0]             r_rem    [SQRT_CELLS+1];
  logic [63:0]             r_root   [SQRT_CELLS+1];
  logic [63:0]             dd_rem   [SQRT_CELLS+1];
  logic [63:0]             dd_root  [SQRT_CELLS+1];
  logic [63:0]             s_rem    [SQRT_CELLS+1];
  logic [63:0]             s_root   [SQRT_CELLS+1];
  logic [63:0]             dv_rem   [DIV_CELLS+1];
  logic [32:0]             dv_den   [DIV_CELLS+1];
  logic [DIV_CELLS-1:0]    dv_q     [DIV_CELLS+1];
  logic signed [63:0]      b_x [N+1], b_y [N+1];
  logic signed [ANG_W-1:0] b_z [N+1];
  logic signed [63:0]      c_x [N+1], c_y [N+1];
  logic signed [ANG_W-1:0] c_z [N+1];
  logic signed [63:0]      g_x [N+1], g_y [N+1];
  logic signed [ANG_W-1:0] g_z [N+1];
  logic signed [63:0]      h_x [N+1], h_y [N+1];
  logic signed [ANG_W-1:0] h_z [N+1];

  // Combinational helpers.
  logic signed [ANG_W-1:0] lat_w, alat_w, gap_w, mu_w, mu_s;
  logic [63:0]             acl_w, asl_w;
  logic [31:0]             ec_w, dd_w;
  logic [30:0]             re_p1;
  logic [31:0]             xa_hi;
  logic signed [34:0]      diff_w;
  logic signed [31:0]      cd_w;
  logic signed [66:0]      rnd_w;
  logic signed [36:0]      alt_g, alt_p, alt_sel;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Register writes and derived ellipsoid products.
  always_ff @(posedge clk) begin
    if (rst) begin
      re <= 30'd637813700;
      e  <= 31'd2140283522;
      w  <= 20'd5206;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIUS: re <= cfg_data[RE_W-1:0];
        REG_RATIO:  e  <= cfg_data;
        REG_WINDOW: w  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ree   <= re * e;
    re_sq <= re * re;
    polar <= RE_W'((ree + (61'd1 << 30)) >> 31);
  end

  // Valid line.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT_LEN-2:0], start & ~busy};
    end
  end

  always_comb begin
    tag_in   = '0;
    tag_in.z = z_cm;
  end

  // Per-stage combinational terms.
  assign lat_w  = tag_line[B_OUT].rxy_zero ?
                  (tag_line[B_OUT].z[31] ? -HALF_PI_Q30 : HALF_PI_Q30) : b_z[N];
  assign alat_w = lat_w[ANG_W-1] ? -lat_w : lat_w;
  assign gap_w  = HALF_PI_Q30 - alat_w;
  assign acl_w  = c_x[N][63] ? 64'(-c_x[N]) : 64'(c_x[N]);
  assign asl_w  = c_y[N][63] ? 64'(-c_y[N]) : 64'(c_y[N]);
  assign ec_w   = ec_prod[62:31];
  assign dd_w   = dd_root[SQRT_CELLS][31:0];
  assign re_p1  = {1'b0, re} + 31'd1;
  assign xa_hi  = xa_prod[61:30];
  assign mu_w   = tag_line[G_OUT].mu_zero ? '0 : g_z[N];
  assign mu_s   = tag_line[G_OUT].lat[ANG_W-1] ? -mu_w : mu_w;
  assign diff_w = $signed({2'b00, tag_line[H_OUT].r}) - $signed({5'd0, tag_line[H_OUT].d});
  assign cd_w   = h_x[N][31:0];
  assign rnd_w  = prod + 67'sd536870912;
  assign alt_g  = rnd_w[66:30];
  assign alt_p  = $signed({4'd0, tag_line[ST_Y1].r}) - $signed({7'd0, polar});
  assign alt_sel = tag_line[ST_Y1].pole ? alt_p : alt_g;

  // Side data line with fields filled in as they are found.
  always_comb begin
    tag_next[0] = tag_in;
    for (int k = 1; k < LAT_LEN; k++) begin
      tag_next[k] = tag_line[k-1];
    end
    tag_next[ST_Q].r         = r_root[SQRT_CELLS][32:0];
    tag_next[ST_Q].rxy_zero  = (rxy_root[SQRT_CELLS] == 64'd0);
    tag_next[ST_LAT].lat     = lat_w;
    tag_next[ST_LAT].pole    = gap_w < $signed(ANG_W'(w));
    tag_next[ST_T1].acl      = acl_w[31:0];
    tag_next[ST_U1].dd_zero  = (dd_w == 32'd0);
    tag_next[ST_U2].over     = {3'd0, ree} >= clamp_prod;
    tag_next[ST_V1].d        = tag_line[E_OUT].dd_zero ? '0 :
                               (tag_line[E_OUT].over ? re : dv_q[DIV_CELLS]);
    tag_next[ST_V5].ex       = ex_prod[60:31];
    tag_next[ST_W1].mu_zero  = (s_root[SQRT_CELLS] == 64'd0) &&
                               (tag_line[F_OUT].ex == '0);
  end

  always_ff @(posedge clk) begin
    tag_line <= tag_next;
  end

  // Magnitudes, squares and the sums under the first square roots.
  always_ff @(posedge clk) begin
    ax   <= x_cm[31] ? 32'(-x_cm) : x_cm;
    ay   <= y_cm[31] ? 32'(-y_cm) : y_cm;
    az   <= z_cm[31] ? 32'(-z_cm) : z_cm;
    sq_x <= ax * ax;
    sq_y <= ay * ay;
    sq_z <= az * az;
    pxy  <= sq_x + sq_y;
    prr  <= sq_x + sq_y + sq_z;
  end

  assign rxy_rem[0]  = pxy;
  assign rxy_root[0] = 64'd0;
  assign r_rem[0]    = prr;
  assign r_root[0]   = 64'd0;

  // Horizontal distance and radius.
  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqa
    eca_sqrt_cell u_rxy (
      .clk(clk), .stage(SQ_W'(j)),
      .rem_in(rxy_rem[j]), .root_in(rxy_root[j]),
      .rem_out(rxy_rem[j+1]), .root_out(rxy_root[j+1])
    );
    eca_sqrt_cell u_r (
      .clk(clk), .stage(SQ_W'(j)),
      .rem_in(r_rem[j]), .root_in(r_root[j]),
      .rem_out(r_rem[j+1]), .root_out(r_root[j+1])
    );
  end

  // Prescaled inputs of the latitude atan2.
  always_ff @(posedge clk) begin
    lat_x0 <= {rxy_root[SQRT_CELLS][39:0], 24'd0};
    lat_y0 <= {{8{tag_line[SQA_OUT].z[31]}}, tag_line[SQA_OUT].z, 24'd0};
  end

  assign b_x[0] = lat_x0;
  assign b_y[0] = lat_y0;
  assign b_z[0] = '0;
  assign c_x[0] = INV_GAIN_Q30;
  assign c_y[0] = '0;
  assign c_z[0] = tag_line[ST_LAT].lat;

  // Geocentric latitude, then its cosine and sine.
  for (genvar j = 0; j < N; j++) begin : g_lat
    localparam cordic_ctl_t VCTL = '{mode: CM_VECTOR, stage: CS_W'(j)};
    localparam cordic_ctl_t RCTL = '{mode: CM_ROTATE, stage: CS_W'(j)};
    eca_cordic_cell u_atan (
      .clk(clk), .ctl(VCTL),
      .x_in(b_x[j]), .y_in(b_y[j]), .z_in(b_z[j]),
      .x_out(b_x[j+1]), .y_out(b_y[j+1]), .z_out(b_z[j+1])
    );
    eca_cordic_cell u_cos (
      .clk(clk), .ctl(RCTL),
      .x_in(c_x[j]), .y_in(c_y[j]), .z_in(c_z[j]),
      .x_out(c_x[j+1]), .y_out(c_y[j+1]), .z_out(c_z[j+1])
    );
  end

  // Scaled cosine and the sum under the ellipse norm root.
  always_ff @(posedge clk) begin
    asl      <= asl_w[31:0];
    ec_prod  <= e * tag_line[ST_T1].acl;
    asl_sq   <= asl * asl;
    ec_sq    <= ec_w * ec_w;
    asl_sq_d <= asl_sq;
    dsum     <= asl_sq_d + ec_sq;
  end

  assign dd_rem[0]  = dsum;
  assign dd_root[0] = 64'd0;

  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqd
    eca_sqrt_cell u_dd (
      .clk(clk), .stage(SQ_W'(j)),
      .rem_in(dd_rem[j]), .root_in(dd_root[j]),
      .rem_out(dd_rem[j+1]), .root_out(dd_root[j+1])
    );
  end

  // Divisor and the test for a quotient above the radius.
  always_ff @(posedge clk) begin
    den        <= {dd_w, 1'b0};
    clamp_prod <= re_p1 * {dd_w, 1'b0};
    den_d      <= den;
  end

  assign dv_rem[0] = {3'd0, ree};
  assign dv_den[0] = den_d;
  assign dv_q[0]   = '0;

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    eca_div_cell u_div (
      .clk(clk), .stage(DV_W'(j)),
      .rem_in(dv_rem[j]), .den_in(dv_den[j]), .q_in(dv_q[j]),
      .rem_out(dv_rem[j+1]), .den_out(dv_den[j+1]), .q_out(dv_q[j+1])
    );
  end

  // Ellipse point and the radicand of its polar coordinate.
  always_ff @(posedge clk) begin
    xa_prod <= tag_line[ST_V1].d * tag_line[ST_V1].acl;
    xa      <= (xa_hi > {2'd0, re}) ? re : xa_hi[RE_W-1:0];
    xa_sq   <= xa * xa;
    ex_prod <= e * xa;
    srad    <= re_sq - xa_sq;
  end

  assign s_rem[0]  = {4'd0, srad};
  assign s_root[0] = 64'd0;

  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqs
    eca_sqrt_cell u_s (
      .clk(clk), .stage(SQ_W'(j)),
      .rem_in(s_rem[j]), .root_in(s_root[j]),
      .rem_out(s_rem[j+1]), .root_out(s_root[j+1])
    );
  end

  // Normal angle inputs, then the angle between normal and radius.
  always_ff @(posedge clk) begin
    mu_x0 <= {10'd0, tag_line[F_OUT].ex, 24'd0};
    mu_y0 <= {s_root[SQRT_CELLS][39:0], 24'd0};
    ang   <= mu_s - tag_line[G_OUT].lat;
  end

  assign g_x[0] = mu_x0;
  assign g_y[0] = mu_y0;
  assign g_z[0] = '0;
  assign h_x[0] = INV_GAIN_Q30;
  assign h_y[0] = '0;
  assign h_z[0] = ang;

  for (genvar j = 0; j < N; j++) begin : g_mu
    localparam cordic_ctl_t VCTL = '{mode: CM_VECTOR, stage: CS_W'(j)};
    localparam cordic_ctl_t RCTL = '{mode: CM_ROTATE, stage: CS_W'(j)};
    eca_cordic_cell u_atan (
      .clk(clk), .ctl(VCTL),
      .x_in(g_x[j]), .y_in(g_y[j]), .z_in(g_z[j]),
      .x_out(g_x[j+1]), .y_out(g_y[j+1]), .z_out(g_z[j+1])
    );
    eca_cordic_cell u_cos (
      .clk(clk), .ctl(RCTL),
      .x_in(h_x[j]), .y_in(h_y[j]), .z_in(h_z[j]),
      .x_out(h_x[j+1]), .y_out(h_y[j+1]), .z_out(h_z[j+1])
    );
  end

  // Projection, branch select and saturation.
  always_ff @(posedge clk) begin
    prod      <= diff_w * cd_w;
    near_pole <= tag_line[ST_Y1].pole;
    if (alt_sel > 37'sd2147483647) begin
      altitude_cm <= 32'sh7fffffff;
      saturated   <= 1'b1;
    end else if (alt_sel < -37'sd2147483648) begin
      altitude_cm <= 32'sh80000000;
      saturated   <= 1'b1;
    end else begin
      altitude_cm <= alt_sel[31:0];
      saturated   <= 1'b0;
    end
  end

  assign done = vld[ST_Y2];

  // Every accepted request produces exactly one result at a fixed latency.
  `ECA_ASSERT_DELAY(a_latency, clk, rst, start && !busy, DONE_DELAY, done, "result missing")
  `ECA_ASSERT_IMP(a_no_phantom, clk, rst, done, $past(start && !busy, DONE_DELAY), "stray result")
  `ECA_ASSERT_IMP(a_sat_clamp, clk, rst, done && saturated,
    altitude_cm == 32'sh7fffffff || altitude_cm == 32'sh80000000, "bad clamp value")

endmodule

### hdl/eca_sqrt_cell.sv
// One registered step of a bit-pair integer square root.
module eca_sqrt_cell import eca_pkg::*; (
  input  logic            clk,
  input  logic [SQ_W-1:0] stage,
  input  logic [63:0]     rem_in,
  input  logic [63:0]     root_in,
  output logic [63:0]     rem_out,
  output logic [63:0]     root_out
);

  logic [6:0]  sh;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic        take;

  // Trial subtraction of the current bit pair.
  assign sh    = 7'd62 - {1'b0, stage, 1'b0};
  assign bitv  = 64'd1 << sh;
  assign trial = root_in + bitv;
  assign take  = rem_in >= trial;

  always_ff @(posedge clk) begin
    if (take) begin
      rem_out  <= rem_in - trial;
      root_out <= (root_in >> 1) + bitv;
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in >> 1;
    end
  end

endmodule

### hdl/eca_div_cell.sv
// One registered step of a restoring divider producing one quotient bit.
module eca_div_cell import eca_pkg::*; (
  input  logic                 clk,
  input  logic [DV_W-1:0]      stage,
  input  logic [63:0]          rem_in,
  input  logic [32:0]          den_in,
  input  logic [DIV_CELLS-1:0] q_in,
  output logic [63:0]          rem_out,
  output logic [32:0]          den_out,
  output logic [DIV_CELLS-1:0] q_out
);

  logic [DV_W-1:0] sh;
  logic [63:0]     trial;
  logic            take;

  // The divisor is aligned to the quotient bit this cell decides.
  assign sh    = DV_W'(DIV_CELLS - 1) - stage;
  assign trial = {31'd0, den_in} << sh;
  assign take  = rem_in >= trial;

  always_ff @(posedge clk) begin
    rem_out <= take ? rem_in - trial : rem_in;
    den_out <= den_in;
    q_out   <= {q_in[DIV_CELLS-2:0], take};
  end

endmodule

### hdl/eca_cordic_cell.sv
// One registered CORDIC micro-rotation, vectoring or rotating.
module eca_cordic_cell import eca_pkg::*; (
  input  logic                    clk,
  input  cordic_ctl_t             ctl,
  input  logic signed [63:0]      x_in,
  input  logic signed [63:0]      y_in,
  input  logic signed [ANG_W-1:0] z_in,
  output logic signed [63:0]      x_out,
  output logic signed [63:0]      y_out,
  output logic signed [ANG_W-1:0] z_out
);

  logic signed [63:0]      dx;
  logic signed [63:0]      dy;
  logic signed [ANG_W-1:0] da;
  logic                    up;

  // Floor shifts and the angle step for this position.
  assign dx = y_in >>> ctl.stage;
  assign dy = x_in >>> ctl.stage;
  assign da = atan_q30(int'(ctl.stage));

  // Vectoring steers on the sign of y, rotation on the residual angle.
  assign up = (ctl.mode == CM_VECTOR) ? y_in[63] : !z_in[ANG_W-1];

  always_ff @(posedge clk) begin
    if (up) begin
      x_out <= x_in - dx;
      y_out <= y_in + dy;
      z_out <= z_in - da;
    end else begin
      x_out <= x_in + dx;
      y_out <= y_in - dy;
      z_out <= z_in + da;
    end
  end

endmodule
